// ----- hw/rtl/obb_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_pkg
// Types, widths and codes shared by the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int CEN_W     = 24;
   localparam int HS_W      = 16;
   localparam int AX_W      = 16;
   localparam int VEC_W     = 48;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 4;

   localparam int D_W    = 25;
   localparam int R_W    = 33;
   localparam int AR_W   = 32;
   localparam int T_W    = 42;
   localparam int TL_W   = 22;
   localparam int TH_W   = T_W - TL_W;
   localparam int PL_W   = TL_W + 1 + R_W;
   localparam int PH_W   = TH_W + R_W;
   localparam int P_W    = 74;
   localparam int PROJ_W = 76;
   localparam int RAD_W  = 50;
   localparam int LIM_W  = 64;
   localparam int CMP_W  = 77;
   localparam int N_TEST = 15;

   localparam int FACE_SHIFT = 28;
   localparam int PROJ_SHIFT = 14;

   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   localparam logic [KIND_W-1:0] KIND_NULL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FINITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INF    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HALF     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_U   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_V   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_W   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_KIND     = 4'd7;

   // result class decided from the two kinds
   localparam logic [1:0] CLS_ZERO = 2'd0;
   localparam logic [1:0] CLS_ONE  = 2'd1;
   localparam logic [1:0] CLS_TEST = 2'd2;

   localparam logic [VEC_W-1:0] AXIS_U_RST = 48'h0000_0000_4000;
   localparam logic [VEC_W-1:0] AXIS_V_RST = 48'h0000_4000_0000;
   localparam logic [VEC_W-1:0] AXIS_W_RST = 48'h4000_0000_0000;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic signed [CEN_W-1:0] center_z;
      logic [VEC_W-1:0]        half_sizes;
      logic [VEC_W-1:0]        axis_u;
      logic [VEC_W-1:0]        axis_v;
      logic [VEC_W-1:0]        axis_w;
      logic [KIND_W-1:0]       kind;
   } obb_cfg_type;

   function automatic logic signed [AX_W-1:0] axis_comp(input logic [VEC_W-1:0] v,
                                                        input int k);
      return $signed(v[AX_W*k +: AX_W]);
   endfunction

   function automatic logic [HS_W-1:0] half_comp(input logic [VEC_W-1:0] v, input int k);
      return v[HS_W*k +: HS_W];
   endfunction

   function automatic logic [1:0] box_class(input logic [KIND_W-1:0] ka,
                                            input logic [KIND_W-1:0] kb);
      logic [1:0] cls;
      if (ka == KIND_NULL || ka == KIND_BAD || kb == KIND_NULL || kb == KIND_BAD) begin
         cls = CLS_ZERO;
      end else if (ka == KIND_INF || kb == KIND_INF) begin
         cls = CLS_ONE;
      end else begin
         cls = CLS_TEST;
      end
      return cls;
   endfunction

endpackage

// ----- hw/rtl/obb_req_if.sv -----
// ----------------------------------------------------------------------------
// obb_req_if
// Request channel: one candidate box per request.
// ----------------------------------------------------------------------------
interface obb_req_if;
   import obb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CEN_W-1:0] cand_center_x;
   logic signed [CEN_W-1:0] cand_center_y;
   logic signed [CEN_W-1:0] cand_center_z;
   logic [VEC_W-1:0]        cand_half_sizes;
   logic [VEC_W-1:0]        cand_axis_u;
   logic [VEC_W-1:0]        cand_axis_v;
   logic [VEC_W-1:0]        cand_axis_w;
   logic [KIND_W-1:0]       cand_kind;
   modport source(output valid, cand_center_x, cand_center_y, cand_center_z,
                  cand_half_sizes, cand_axis_u, cand_axis_v, cand_axis_w, cand_kind,
                  input ready);
   modport sink(input valid, cand_center_x, cand_center_y, cand_center_z,
                cand_half_sizes, cand_axis_u, cand_axis_v, cand_axis_w, cand_kind,
                output ready);
endinterface

// ----- hw/rtl/obb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// obb_rsp_if
// Response channel: overlap flag per request.
// ----------------------------------------------------------------------------
interface obb_rsp_if;
   logic valid;
   logic ready;
   logic overlap;
   modport source(output valid, overlap, input ready);
   modport sink(input valid, overlap, output ready);
endinterface

// ----- hw/rtl/obb_csr_if.sv -----
// ----------------------------------------------------------------------------
// obb_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface obb_csr_if;
   import obb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VEC_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/oriented_box_overlap_test_top.sv -----
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_top
// Separating axis overlap test of a candidate box against a reference box.
// ----------------------------------------------------------------------------
// Usage:
//   csr_chan  writes the reference box (centers, half sizes, axes, kind).
//             Always ready; write only while no request is in flight.
//   req_chan  one candidate box per request.
//   rsp_chan  one overlap flag per request, in request order.
// Throughput: one request per cycle while rsp_chan is not held; the seven-stage pipeline
//   (difference, rotation and translation, abs, partial products, radii,
//   projections, compare) holds one request per stage.
// Stall: when the response is held, the whole pipeline holds and
//   req_chan.ready drops; nothing is lost or repeated.
// Reset: pipeline empty, reference box null with identity axes.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_top (
   input  logic    clock,
   input  logic    reset,
   obb_req_if.sink req_chan,
   obb_rsp_if.source rsp_chan,
   obb_csr_if.sink csr_chan
);
   import obb_pkg::*;

   obb_cfg_type cfg;
   logic        adv;
   logic [7:1]  vld_ff;
   logic [1:0]  cls_ff [1:7];

   logic signed [D_W-1:0]    d1_in  [3], d1_ff [3];
   logic [VEC_W-1:0]         hb1_ff;
   logic [VEC_W-1:0]         bax1_ff [3];
   logic signed [R_W-1:0]    r2_in  [3][3], r2_ff [3][3], r3_ff [3][3];
   logic signed [T_W-1:0]    t2_in  [3], t2_ff [3], t3_ff [3], t4_ff [3], t5_ff [3];
   logic [VEC_W-1:0]         hb2_ff, hb3_ff, hb4_ff;
   logic [AR_W-1:0]          ar3_in [3][3], ar3_ff [3][3];
   logic signed [PL_W-1:0]   pl4_in [3][3][3], pl4_ff [3][3][3];
   logic signed [PH_W-1:0]   ph4_in [3][3][3], ph4_ff [3][3][3];
   logic [RAD_W-1:0]         qa4_in [3][3][3], qa4_ff [3][3][3];
   logic [RAD_W-1:0]         qb4_in [3][3][3], qb4_ff [3][3][3];
   logic signed [P_W-1:0]    p5_in  [3][3][3], p5_ff [3][3][3];
   logic [RAD_W-1:0]         rada5_in [3], rada5_ff [3];
   logic [RAD_W-1:0]         radb5_in [3], radb5_ff [3];
   logic [RAD_W-1:0]         rade5_in [3][3], rade5_ff [3][3];
   logic signed [PROJ_W-1:0] proj6_in [N_TEST], proj6_ff [N_TEST];
   logic [LIM_W-1:0]         lim6_in [N_TEST], lim6_ff [N_TEST];
   logic [N_TEST-1:0]        sep7;
   logic                     ovl_in, ovl_ff;

   obb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   assign adv            = !vld_ff[7] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[7];
   assign rsp_chan.overlap = ovl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[6:1], req_chan.valid};
      end
   end

   // stage 1: center difference
   always_comb begin
      d1_in[0] = D_W'(req_chan.cand_center_x) - D_W'(cfg.center_x);
      d1_in[1] = D_W'(req_chan.cand_center_y) - D_W'(cfg.center_y);
      d1_in[2] = D_W'(req_chan.cand_center_z) - D_W'(cfg.center_z);
   end

   // stage 2: rotation and translation
   always_comb begin
      logic [VEC_W-1:0] a [3];
      a[0] = cfg.axis_u;
      a[1] = cfg.axis_v;
      a[2] = cfg.axis_w;
      for (int i = 0; i < 3; i++) begin
         t2_in[i] = '0;
         for (int k = 0; k < 3; k++) begin
            t2_in[i] = t2_in[i] + T_W'(d1_ff[k]) * T_W'(axis_comp(a[i], k));
         end
         for (int j = 0; j < 3; j++) begin
            r2_in[i][j] = '0;
            for (int k = 0; k < 3; k++) begin
               r2_in[i][j] = r2_in[i][j]
                  + R_W'(axis_comp(a[i], k)) * R_W'(axis_comp(bax1_ff[j], k));
            end
         end
      end
   end

   // stage 3: absolute rotation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ar3_in[i][j] = r2_ff[i][j][R_W-1] ? AR_W'(-r2_ff[i][j]) : AR_W'(r2_ff[i][j]);
         end
      end
   end

   // stage 4: partial products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               pl4_in[k][m][j] = PL_W'($signed({1'b0, t3_ff[k][TL_W-1:0]}))
                               * PL_W'(r3_ff[m][j]);
               ph4_in[k][m][j] = PH_W'($signed(t3_ff[k][T_W-1:TL_W])) * PH_W'(r3_ff[m][j]);
               qa4_in[k][m][j] = RAD_W'(half_comp(cfg.half_sizes, k)) * RAD_W'(ar3_ff[m][j]);
               qb4_in[k][m][j] = RAD_W'(half_comp(hb3_ff, k)) * RAD_W'(ar3_ff[m][j]);
            end
         end
      end
   end

   // stage 5: full products and radii
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               p5_in[k][m][j] = (P_W'(ph4_ff[k][m][j]) <<< TL_W) + P_W'(pl4_ff[k][m][j]);
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         rada5_in[i] = (RAD_W'(half_comp(cfg.half_sizes, i)) << FACE_SHIFT)
                     + qb4_ff[0][i][0] + qb4_ff[1][i][1] + qb4_ff[2][i][2];
         radb5_in[i] = (RAD_W'(half_comp(hb4_ff, i)) << FACE_SHIFT)
                     + qa4_ff[0][0][i] + qa4_ff[1][1][i] + qa4_ff[2][2][i];
         for (int j = 0; j < 3; j++) begin
            rade5_in[i][j] = qa4_ff[NXT1[i]][NXT2[i]][j] + qa4_ff[NXT2[i]][NXT1[i]][j]
                           + qb4_ff[NXT1[j]][i][NXT2[j]] + qb4_ff[NXT2[j]][i][NXT1[j]];
         end
      end
   end

   // stage 6: projections and limits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         proj6_in[i]   = PROJ_W'(t5_ff[i]) <<< PROJ_SHIFT;
         lim6_in[i]    = LIM_W'(rada5_ff[i]);
         proj6_in[3+i] = PROJ_W'(p5_ff[0][0][i]) + PROJ_W'(p5_ff[1][1][i])
                       + PROJ_W'(p5_ff[2][2][i]);
         lim6_in[3+i]  = LIM_W'(radb5_ff[i]) << PROJ_SHIFT;
         for (int j = 0; j < 3; j++) begin
            proj6_in[6+3*i+j] = PROJ_W'(p5_ff[NXT2[i]][NXT1[i]][j])
                              - PROJ_W'(p5_ff[NXT1[i]][NXT2[i]][j]);
            lim6_in[6+3*i+j]  = LIM_W'(rade5_ff[i][j]) << PROJ_SHIFT;
         end
      end
   end

   // stage 7: |proj| > lim as proj > lim or proj + lim < 0
   always_comb begin
      for (int n = 0; n < N_TEST; n++) begin
         sep7[n] = ($signed(CMP_W'(proj6_ff[n])) > $signed({13'd0, lim6_ff[n]}))
                || ((CMP_W'(proj6_ff[n]) + $signed({13'd0, lim6_ff[n]})) < 0);
      end
      ovl_in = (cls_ff[6] == CLS_ONE) || ((cls_ff[6] == CLS_TEST) && !(|sep7));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cls_ff[1] <= box_class(cfg.kind, req_chan.cand_kind);
         for (int s = 2; s <= 7; s++) begin
            cls_ff[s] <= cls_ff[s-1];
         end
         d1_ff    <= d1_in;
         hb1_ff   <= req_chan.cand_half_sizes;
         bax1_ff[0] <= req_chan.cand_axis_u;
         bax1_ff[1] <= req_chan.cand_axis_v;
         bax1_ff[2] <= req_chan.cand_axis_w;
         r2_ff    <= r2_in;
         t2_ff    <= t2_in;
         hb2_ff   <= hb1_ff;
         r3_ff    <= r2_ff;
         t3_ff    <= t2_ff;
         ar3_ff   <= ar3_in;
         hb3_ff   <= hb2_ff;
         pl4_ff   <= pl4_in;
         ph4_ff   <= ph4_in;
         qa4_ff   <= qa4_in;
         qb4_ff   <= qb4_in;
         t4_ff    <= t3_ff;
         hb4_ff   <= hb3_ff;
         p5_ff    <= p5_in;
         rada5_ff <= rada5_in;
         radb5_ff <= radb5_in;
         rade5_ff <= rade5_in;
         t5_ff    <= t4_ff;
         proj6_ff <= proj6_in;
         lim6_ff  <= lim6_in;
         ovl_ff   <= ovl_in;
      end
   end

   a_null_cls : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready
      && (req_chan.cand_kind == KIND_NULL || req_chan.cand_kind == KIND_BAD)
      |=> vld_ff[1] && cls_ff[1] == CLS_ZERO)
      else $error("null candidate not classed as no overlap");

   a_null_out : assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] && cls_ff[7] == CLS_ZERO |-> !ovl_ff)
      else $error("null box reported as overlapping");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved during stall");

   a_reset : assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");

endmodule

// ----- hw/rtl/obb_csr.sv -----
// ----------------------------------------------------------------------------
// obb_csr
// Reference box registers. Writes beyond the last index are dropped.
// ----------------------------------------------------------------------------
module obb_csr (
   input  logic               clock,
   input  logic               reset,
   obb_csr_if.sink            csr_chan,
   output obb_pkg::obb_cfg_type cfg
);
   import obb_pkg::*;

   obb_cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x   <= '0;
         cfg_ff.center_y   <= '0;
         cfg_ff.center_z   <= '0;
         cfg_ff.half_sizes <= '0;
         cfg_ff.axis_u     <= AXIS_U_RST;
         cfg_ff.axis_v     <= AXIS_V_RST;
         cfg_ff.axis_w     <= AXIS_W_RST;
         cfg_ff.kind       <= KIND_NULL;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_CENTER_X: cfg_ff.center_x   <= $signed(csr_chan.data[CEN_W-1:0]);
            REG_CENTER_Y: cfg_ff.center_y   <= $signed(csr_chan.data[CEN_W-1:0]);
            REG_CENTER_Z: cfg_ff.center_z   <= $signed(csr_chan.data[CEN_W-1:0]);
            REG_HALF:     cfg_ff.half_sizes <= csr_chan.data;
            REG_AXIS_U:   cfg_ff.axis_u     <= csr_chan.data;
            REG_AXIS_V:   cfg_ff.axis_v     <= csr_chan.data;
            REG_AXIS_W:   cfg_ff.axis_w     <= csr_chan.data;
            REG_KIND:     cfg_ff.kind       <= csr_chan.data[KIND_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the oriented box overlap test.
// Candidate boxes are sent against several reference box settings. Each
// request's overlap flag is predicted with exact wide integer arithmetic over
// the fifteen separating axes and checked in order as responses arrive.
// Both sides idle at random, and the response side holds off for long
// stretches so that the pipeline fills and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import obb_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic signed [CEN_W-1:0] center_z;
      logic [VEC_W-1:0]        half_sizes;
      logic [VEC_W-1:0]        axis_u;
      logic [VEC_W-1:0]        axis_v;
      logic [VEC_W-1:0]        axis_w;
      logic [KIND_W-1:0]       kind;
   } cand_box_type;

   logic clock;
   logic reset;

   obb_req_if req_chan ();
   obb_rsp_if rsp_chan ();
   obb_csr_if csr_chan ();

   oriented_box_overlap_test_top DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   obb_cfg_type  ref_box;
   cand_box_type pending_boxes[$];
   bit           overlap_expected[$];
   int           mismatch_count = 0;
   int           rsp_count = 0;
   bit           idling_on = 1;
   bit           req_taken;
   int           hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] %s", $realtime, msg);
   endtask

   function automatic wide_type wabs(input wide_type x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic bit predict_overlap(input obb_cfg_type rb, input cand_box_type cb);
      longint ha[3], hb[3], d[3], t[3];
      longint a[3][3], b[3][3], r[3][3], ar[3][3];
      longint rad;
      wide_type p;
      logic [VEC_W-1:0] ra[3], ca[3];
      int i1, i2, j1, j2;
      if (rb.kind == KIND_NULL || rb.kind == KIND_BAD ||
          cb.kind == KIND_NULL || cb.kind == KIND_BAD) return 1'b0;
      if (rb.kind == KIND_INF || cb.kind == KIND_INF) return 1'b1;
      ra = '{rb.axis_u, rb.axis_v, rb.axis_w};
      ca = '{cb.axis_u, cb.axis_v, cb.axis_w};
      d[0] = longint'(cb.center_x) - longint'(rb.center_x);
      d[1] = longint'(cb.center_y) - longint'(rb.center_y);
      d[2] = longint'(cb.center_z) - longint'(rb.center_z);
      for (int k = 0; k < 3; k++) begin
         ha[k] = longint'(rb.half_sizes[16*k +: 16]);
         hb[k] = longint'(cb.half_sizes[16*k +: 16]);
         for (int i = 0; i < 3; i++) begin
            a[i][k] = longint'($signed(ra[i][16*k +: 16]));
            b[i][k] = longint'($signed(ca[i][16*k +: 16]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         t[i] = 0;
         for (int j = 0; j < 3; j++) begin
            r[i][j] = 0;
            for (int k = 0; k < 3; k++) r[i][j] += a[i][k] * b[j][k];
            ar[i][j] = (r[i][j] < 0) ? -r[i][j] : r[i][j];
         end
         for (int k = 0; k < 3; k++) t[i] += d[k] * a[i][k];
      end
      for (int i = 0; i < 3; i++) begin
         rad = (ha[i] <<< 28) + hb[0] * ar[i][0] + hb[1] * ar[i][1] + hb[2] * ar[i][2];
         if (wabs(wide_type'(t[i]) * 16384) > wide_type'(rad)) return 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         rad = ha[0] * ar[0][i] + ha[1] * ar[1][i] + ha[2] * ar[2][i] + (hb[i] <<< 28);
         p = wide_type'(t[0]) * wide_type'(r[0][i]) + wide_type'(t[1]) * wide_type'(r[1][i])
           + wide_type'(t[2]) * wide_type'(r[2][i]);
         if (wabs(p) > wide_type'(rad) * 16384) return 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            rad = ha[i1] * ar[i2][j] + ha[i2] * ar[i1][j]
                + hb[j1] * ar[i][j2] + hb[j2] * ar[i][j1];
            p = wide_type'(t[i2]) * wide_type'(r[i1][j])
              - wide_type'(t[i1]) * wide_type'(r[i2][j]);
            if (wabs(p) > wide_type'(rad) * 16384) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [VEC_W-1:0] rand48();
      return VEC_W'({$urandom, $urandom});
   endfunction

   function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // orthonormal-ish frame: signed permutation, 45 degree turn, or raw bits
   task automatic pick_frame(output logic [VEC_W-1:0] u, v, w);
      int perm, sel;
      logic [VEC_W-1:0] e[3];
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         perm = $urandom_range(0, 2);
         e[0] = vec3(($urandom_range(0, 1) ? 16384 : -16384), 0, 0);
         e[1] = vec3(0, ($urandom_range(0, 1) ? 16384 : -16384), 0);
         e[2] = vec3(0, 0, ($urandom_range(0, 1) ? 16384 : -16384));
         u = e[perm];
         v = e[(perm + 1) % 3];
         w = e[(perm + 2) % 3];
      end else if (sel < 9) begin
         u = vec3(11585, 11585, 0);
         v = vec3(-11585, 11585, 0);
         w = vec3(0, 0, 16384);
         if (sel == 8) begin
            u = vec3(16384, 0, 0);
            v = vec3(0, 11585, 11585);
            w = vec3(0, -11585, 11585);
         end
      end else begin
         u = rand48();
         v = rand48();
         w = rand48();
      end
   endtask

   function automatic logic [VEC_W-1:0] rand_halves(input int hmax);
      return vec3($urandom_range(0, hmax), $urandom_range(0, hmax), $urandom_range(0, hmax));
   endfunction

   function automatic logic [KIND_W-1:0] rand_kind();
      int s;
      s = $urandom_range(0, 99);
      if (s < 82) return KIND_FINITE;
      if (s < 88) return KIND_INF;
      if (s < 94) return KIND_NULL;
      return KIND_BAD;
   endfunction

   task automatic gen_candidate(output cand_box_type cb);
      int span;
      if ($urandom_range(0, 99) < 12) begin
         cb = {rand48(), rand48(), rand48(), rand48(), rand48(), 26'($urandom)};
         cb.kind = KIND_W'($urandom_range(0, 3));
      end else begin
         span = $urandom_range(0, 1) ? 'h0400 : 'h1800;
         cb.center_x = ref_box.center_x + CEN_W'($signed($urandom_range(0, 2*span)) - span);
         cb.center_y = ref_box.center_y + CEN_W'($signed($urandom_range(0, 2*span)) - span);
         cb.center_z = ref_box.center_z + CEN_W'($signed($urandom_range(0, 2*span)) - span);
         cb.half_sizes = rand_halves($urandom_range(0, 1) ? 'h0200 : 'h0C00);
         pick_frame(cb.axis_u, cb.axis_v, cb.axis_w);
         cb.kind = rand_kind();
      end
   endtask

   function automatic cand_box_type mk_box(input int cx, cy, cz,
                                           input logic [VEC_W-1:0] hs,
                                           input logic [VEC_W-1:0] u, v, w,
                                           input logic [KIND_W-1:0] kind);
      cand_box_type cb;
      cb.center_x = CEN_W'(cx);
      cb.center_y = CEN_W'(cy);
      cb.center_z = CEN_W'(cz);
      cb.half_sizes = hs;
      cb.axis_u = u;
      cb.axis_v = v;
      cb.axis_w = w;
      cb.kind = kind;
      return cb;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [VEC_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_CENTER_X: ref_box.center_x   = data[CEN_W-1:0];
         REG_CENTER_Y: ref_box.center_y   = data[CEN_W-1:0];
         REG_CENTER_Z: ref_box.center_z   = data[CEN_W-1:0];
         REG_HALF:     ref_box.half_sizes = data;
         REG_AXIS_U:   ref_box.axis_u     = data;
         REG_AXIS_V:   ref_box.axis_v     = data;
         REG_AXIS_W:   ref_box.axis_w     = data;
         REG_KIND:     ref_box.kind       = data[KIND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_ref(input obb_cfg_type rb);
      csr_write(REG_CENTER_X, {{24{rb.center_x[CEN_W-1]}}, rb.center_x});
      csr_write(REG_CENTER_Y, {24'(rand48() >> 24), rb.center_y});
      csr_write(REG_CENTER_Z, {{24{rb.center_z[CEN_W-1]}}, rb.center_z});
      csr_write(REG_HALF, rb.half_sizes);
      csr_write(REG_AXIS_U, rb.axis_u);
      csr_write(REG_AXIS_V, rb.axis_v);
      csr_write(REG_AXIS_W, rb.axis_w);
      csr_write(REG_KIND, {46'(rand48()), rb.kind});
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_boxes.size() == 0 && !req_chan.valid && overlap_expected.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   // request side: prediction on accept, then the driver
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
      if (req_chan.valid && req_chan.ready)
         overlap_expected.push_back(predict_overlap(ref_box,
            cand_box_type'({req_chan.cand_center_x, req_chan.cand_center_y,
                            req_chan.cand_center_z, req_chan.cand_half_sizes,
                            req_chan.cand_axis_u, req_chan.cand_axis_v,
                            req_chan.cand_axis_w, req_chan.cand_kind})));
   end

   always @(negedge clock) begin
      cand_box_type cb;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_boxes.size() > 0 && !(idling_on && $urandom_range(0, 99) < 11)) begin
            cb = pending_boxes.pop_front();
            req_chan.valid           <= 1'b1;
            req_chan.cand_center_x   <= cb.center_x;
            req_chan.cand_center_y   <= cb.center_y;
            req_chan.cand_center_z   <= cb.center_z;
            req_chan.cand_half_sizes <= cb.half_sizes;
            req_chan.cand_axis_u     <= cb.axis_u;
            req_chan.cand_axis_v     <= cb.axis_v;
            req_chan.cand_axis_w     <= cb.axis_w;
            req_chan.cand_kind       <= cb.kind;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response side: random stalls plus a long hold every 500 responses
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_count % 500 == 250 && rsp_chan.ready) begin
         hold_cycles <= 80;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idling_on && $urandom_range(0, 99) < 11);
      end
   end

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count <= rsp_count + 1;
         if (overlap_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected response overlap=%0b", rsp_chan.overlap));
         end else begin
            want = overlap_expected.pop_front();
            if (rsp_chan.overlap !== want)
               report_mismatch($sformatf("response %0d: overlap=%b, predicted %0b",
                                         rsp_count, rsp_chan.overlap, want));
         end
      end
   end

   initial begin
      obb_cfg_type  rb;
      cand_box_type cb;
      logic [VEC_W-1:0] one3, ident_u, ident_v, ident_w;
      one3    = vec3('h100, 'h100, 'h100);
      ident_u = AXIS_U_RST;
      ident_v = AXIS_V_RST;
      ident_w = AXIS_W_RST;
      reset = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      req_chan.valid = 1'b0;
      req_chan.cand_center_x = '0;
      req_chan.cand_center_y = '0;
      req_chan.cand_center_z = '0;
      req_chan.cand_half_sizes = '0;
      req_chan.cand_axis_u = '0;
      req_chan.cand_axis_v = '0;
      req_chan.cand_axis_w = '0;
      req_chan.cand_kind = KIND_NULL;
      rsp_chan.ready = 1'b0;
      ref_box = '{center_x: '0, center_y: '0, center_z: '0, half_sizes: '0,
                  axis_u: AXIS_U_RST, axis_v: AXIS_V_RST, axis_w: AXIS_W_RST,
                  kind: KIND_NULL};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset state: null reference box
      pending_boxes.push_back(mk_box(0, 0, 0, one3, ident_u, ident_v, ident_w, KIND_FINITE));
      pending_boxes.push_back(mk_box(0, 0, 0, one3, ident_u, ident_v, ident_w, KIND_INF));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         rb = '{center_x: '0, center_y: '0, center_z: '0, half_sizes: one3,
                axis_u: ident_u, axis_v: ident_v, axis_w: ident_w, kind: KIND_FINITE};
         case (ph)
            0: ;
            1: begin
               rb.center_x = 24'h800000;
               rb.center_y = 24'h7FFFFF;
               rb.center_z = 24'h800000;
               rb.half_sizes = '1;
            end
            2: rb.kind = KIND_INF;
            3: rb.kind = KIND_NULL;
            4: begin
               rb.kind = KIND_BAD;
               rb.axis_u = '1;
            end
            default: begin
               rb.center_x = CEN_W'($urandom);
               rb.center_y = CEN_W'($urandom_range(0, 'h4000));
               rb.center_z = CEN_W'(-$urandom_range(0, 'h4000));
               rb.half_sizes = rand_halves('h0A00);
               pick_frame(rb.axis_u, rb.axis_v, rb.axis_w);
            end
         endcase
         idling_on = (ph != 6);
         load_ref(rb);
         if (ph == 3) csr_write(4'd8 + 4'($urandom_range(0, 7)), rand48());
         if (ph == 3) begin
            @(negedge clock);
            csr_chan.valid <= 1'b0;
         end
         if (ph == 0) begin
            for (int k = 0; k < 4; k++)
               pending_boxes.push_back(mk_box(0, 0, 0, one3, ident_u, ident_v, ident_w,
                                              KIND_W'(k)));
            // touching faces overlap, one LSB further does not
            pending_boxes.push_back(mk_box('h200, 0, 0, one3, ident_u, ident_v, ident_w,
                                           KIND_FINITE));
            pending_boxes.push_back(mk_box('h201, 0, 0, one3, ident_u, ident_v, ident_w,
                                           KIND_FINITE));
            pending_boxes.push_back(mk_box(0, -'h200, 0, one3, ident_u, ident_v, ident_w,
                                           KIND_FINITE));
            pending_boxes.push_back(mk_box(0, 0, -'h201, one3, ident_u, ident_v, ident_w,
                                           KIND_FINITE));
            pending_boxes.push_back(mk_box('h200, 'h200, 0, one3, vec3(11585, 11585, 0),
                                           vec3(-11585, 11585, 0), ident_w, KIND_FINITE));
            pending_boxes.push_back(mk_box('h7FFFFF, 'h7FFFFF, 'h7FFFFF, '1, ident_u,
                                           ident_v, ident_w, KIND_FINITE));
            pending_boxes.push_back(mk_box(-'h800000, -'h800000, -'h800000, '1, ident_u,
                                           ident_v, ident_w, KIND_FINITE));
            pending_boxes.push_back(mk_box(0, 0, 0, '1, vec3(-32768, -32768, -32768),
                                           vec3(32767, 32767, 32767), '1, KIND_FINITE));
            pending_boxes.push_back(mk_box(0, 0, 0, '0, '0, '0, '0, KIND_FINITE));
            pending_boxes.push_back(mk_box('h300, 'h100, 0, '0, ident_u, ident_v, ident_w,
                                           KIND_FINITE));
            pending_boxes.push_back(mk_box(-1, -1, -1, '1, '1, '1, '1, KIND_BAD));
            pending_boxes.push_back(mk_box('h150, 'h150, 'h150, one3, vec3(16384, 0, 0),
                                           vec3(0, 11585, 11585), vec3(0, -11585, 11585),
                                           KIND_FINITE));
         end
         for (int n = 0; n < 228; n++) begin
            gen_candidate(cb);
            pending_boxes.push_back(cb);
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
